@@ rtl/nns_pkg.sv @@
// Shared types, sizes and helpers for the NAND netlist simulator.
package nns_pkg;

    // Store sizes
    localparam int WIRE_DEPTH = 4096;
    localparam int GATE_DEPTH = 4096;

    // Field widths
    localparam int ID_W   = 12;
    localparam int MODE_W = 3;

    // Derived widths
    localparam int WIRE_AW = (WIRE_DEPTH > 1) ? $clog2(WIRE_DEPTH) : 1;
    localparam int GATE_AW = (GATE_DEPTH > 1) ? $clog2(GATE_DEPTH) : 1;
    localparam int WCNT_W  = $clog2(WIRE_DEPTH + 1);
    localparam int GCNT_W  = $clog2(GATE_DEPTH + 1);

    // Request codes
    typedef enum logic [MODE_W-1:0] {
        MODE_CLEAR = 3'd0,
        MODE_ALLOC = 3'd1,
        MODE_GATE  = 3'd2,
        MODE_WRITE = 3'd3,
        MODE_READ  = 3'd4,
        MODE_SIM   = 3'd5
    } mode_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_SIM
    } state_t;

    // One stored gate: two inputs and one output wire id
    typedef struct packed {
        logic [ID_W-1:0] a;
        logic [ID_W-1:0] b;
        logic [ID_W-1:0] out;
    } gate_t;

    // True when a wire id falls inside the wire store
    function automatic logic wire_ok(input logic [ID_W-1:0] id);
        return 32'(id) < WIRE_DEPTH;
    endfunction

    // Wire store address of a wire id
    function automatic logic [WIRE_AW-1:0] wire_addr(input logic [ID_W-1:0] id);
        return WIRE_AW'(id);
    endfunction

endpackage

@@ rtl/nand_netlist_simulator.sv @@
// NAND netlist simulator: wire store, gate table and pass sequencer.
//
//  channel   direction  handshake                     payload
//  request   in         start && !busy                mode, wire_a, wire_b, wire_out, bit_value
//  result    out        done (one cycle, no stall)    read_bit, new_id, status
//
// Every request gives one result. Clear, allocate, add gate, write, unused codes and a
// pass over an empty gate table answer in the cycle after the request; a read answers
// from the read state, after the registered read of the wire store. A simulate pass
// streams one gate per cycle from the gate table and answers once its pipeline has
// drained. After reset a clearing pass zeroes the wire store, one entry a cycle, with
// busy high. The receiver cannot stall results.
module nand_netlist_simulator
    import nns_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [MODE_W-1:0] mode,
    input  logic [ID_W-1:0]   wire_a,
    input  logic [ID_W-1:0]   wire_b,
    input  logic [ID_W-1:0]   wire_out,
    input  logic              bit_value,
    output logic              done,
    output logic              read_bit,
    output logic [ID_W-1:0]   new_id,
    output logic              status
);

    // Control state
    state_t              state_reg, state_next;
    logic [WIRE_AW-1:0]  clr_reg, clr_next;
    logic [WCNT_W-1:0]   wires_used_reg, wires_used_next;
    logic [GCNT_W-1:0]   gates_used_reg, gates_used_next;
    logic [GCNT_W-1:0]   g_reg, g_next;
    logic                v1_reg, v1_next;
    logic                v2_reg, v2_next;
    logic                wl_v_reg, wl_v_next;
    logic                done_reg, done_next;

    // Pass pipeline payload
    logic [ID_W-1:0]     s2_a_reg, s2_a_next;
    logic [ID_W-1:0]     s2_b_reg, s2_b_next;
    logic [ID_W-1:0]     s2_o_reg, s2_o_next;
    logic                s2_ina_reg, s2_ina_next;
    logic                s2_inb_reg, s2_inb_next;
    logic                s2_ino_reg, s2_ino_next;
    logic [ID_W-1:0]     wl_addr_reg, wl_addr_next;
    logic                wl_data_reg, wl_data_next;

    // Result payload
    logic                read_bit_reg, read_bit_next;
    logic [ID_W-1:0]     new_id_reg, new_id_next;
    logic                status_reg, status_next;

    // Memory ports
    logic                wire_mem [WIRE_DEPTH];
    gate_t               gate_mem [GATE_DEPTH];
    logic                wm_we;
    logic [WIRE_AW-1:0]  wm_waddr;
    logic                wm_wdata;
    logic [WIRE_AW-1:0]  wm_raddr_a, wm_raddr_b;
    logic                wm_rdata_a, wm_rdata_b;
    logic                gm_we;
    logic [GATE_AW-1:0]  gm_waddr, gm_raddr;
    gate_t               gm_wdata, gm_rdata;

    logic                accept;
    logic                issue;
    logic                drained;
    logic                x_bit, y_bit;

    assign accept  = start && (state_reg == ST_IDLE);
    assign issue   = g_reg < gates_used_reg;
    assign drained = !issue && !v1_reg && !v2_reg;

    // Wire store: one write port, two read ports, read before write
    always_ff @(posedge clk)
    begin
        if (wm_we)
        begin
            wire_mem[wm_waddr] <= wm_wdata;
        end
        wm_rdata_a <= wire_mem[wm_raddr_a];
        wm_rdata_b <= wire_mem[wm_raddr_b];
    end

    // Gate table: one write port, one read port
    always_ff @(posedge clk)
    begin
        if (gm_we)
        begin
            gate_mem[gm_waddr] <= gm_wdata;
        end
        gm_rdata <= gate_mem[gm_raddr];
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == WIRE_AW'(WIRE_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    if (mode_t'(mode) == MODE_READ)
                    begin
                        state_next = ST_READ;
                    end
                    else if (mode_t'(mode) == MODE_SIM && gates_used_reg != '0)
                    begin
                        state_next = ST_SIM;
                    end
                end
            end
            ST_READ:
            begin
                state_next = ST_IDLE;
            end
            ST_SIM:
            begin
                if (drained)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        clr_next        = clr_reg;
        wires_used_next = wires_used_reg;
        gates_used_next = gates_used_reg;
        g_next          = g_reg;
        v1_next         = 1'b0;
        v2_next         = 1'b0;
        wl_v_next       = 1'b0;
        wl_addr_next    = wl_addr_reg;
        wl_data_next    = wl_data_reg;
        s2_a_next       = s2_a_reg;
        s2_b_next       = s2_b_reg;
        s2_o_next       = s2_o_reg;
        s2_ina_next     = s2_ina_reg;
        s2_inb_next     = s2_inb_reg;
        s2_ino_next     = s2_ino_reg;
        done_next       = 1'b0;
        read_bit_next   = 1'b0;
        new_id_next     = '0;
        status_next     = 1'b0;
        wm_we           = 1'b0;
        wm_waddr        = '0;
        wm_wdata        = 1'b0;
        wm_raddr_a      = '0;
        wm_raddr_b      = '0;
        gm_we           = 1'b0;
        gm_waddr        = GATE_AW'(gates_used_reg);
        gm_wdata        = '{a: wire_a, b: wire_b, out: wire_out};
        gm_raddr        = GATE_AW'(g_reg);
        x_bit           = 1'b0;
        y_bit           = 1'b0;

        case (state_reg)
            // Zero the wire store after reset
            ST_CLEAR:
            begin
                wm_we    = 1'b1;
                wm_waddr = clr_reg;
                clr_next = clr_reg + 1'b1;
            end

            // Decode a new request
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (mode_t'(mode))
                        MODE_CLEAR:
                        begin
                            wires_used_next = '0;
                            gates_used_next = '0;
                            done_next       = 1'b1;
                        end
                        MODE_ALLOC:
                        begin
                            if (wires_used_reg < WCNT_W'(WIRE_DEPTH))
                            begin
                                new_id_next     = ID_W'(wires_used_reg);
                                wires_used_next = wires_used_reg + 1'b1;
                            end
                            else
                            begin
                                status_next = 1'b1;
                            end
                            done_next = 1'b1;
                        end
                        MODE_GATE:
                        begin
                            if (gates_used_reg < GCNT_W'(GATE_DEPTH))
                            begin
                                gm_we           = 1'b1;
                                new_id_next     = ID_W'(gates_used_reg);
                                gates_used_next = gates_used_reg + 1'b1;
                            end
                            else
                            begin
                                status_next = 1'b1;
                            end
                            done_next = 1'b1;
                        end
                        MODE_WRITE:
                        begin
                            wm_we     = wire_ok(wire_a);
                            wm_waddr  = wire_addr(wire_a);
                            wm_wdata  = bit_value;
                            done_next = 1'b1;
                        end
                        MODE_READ:
                        begin
                            wm_raddr_a  = wire_addr(wire_a);
                            s2_ina_next = wire_ok(wire_a);
                        end
                        MODE_SIM:
                        begin
                            g_next = '0;
                            if (gates_used_reg == '0)
                            begin
                                done_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end

            // Return the wire read
            ST_READ:
            begin
                read_bit_next = wm_rdata_a & s2_ina_reg;
                done_next     = 1'b1;
            end

            // Stream gates: fetch, read inputs, evaluate and write back
            ST_SIM:
            begin
                if (issue)
                begin
                    g_next  = g_reg + 1'b1;
                    v1_next = 1'b1;
                end
                if (v1_reg)
                begin
                    wm_raddr_a  = wire_addr(gm_rdata.a);
                    wm_raddr_b  = wire_addr(gm_rdata.b);
                    s2_a_next   = gm_rdata.a;
                    s2_b_next   = gm_rdata.b;
                    s2_o_next   = gm_rdata.out;
                    s2_ina_next = wire_ok(gm_rdata.a);
                    s2_inb_next = wire_ok(gm_rdata.b);
                    s2_ino_next = wire_ok(gm_rdata.out);
                    v2_next     = 1'b1;
                end
                if (v2_reg)
                begin
                    // Forward the write of the previous gate, which the read missed
                    x_bit = (wl_v_reg && wl_addr_reg == s2_a_reg) ? wl_data_reg
                                                                  : (wm_rdata_a & s2_ina_reg);
                    y_bit = (wl_v_reg && wl_addr_reg == s2_b_reg) ? wl_data_reg
                                                                  : (wm_rdata_b & s2_inb_reg);
                    wm_we        = s2_ino_reg;
                    wm_waddr     = wire_addr(s2_o_reg);
                    wm_wdata     = ~(x_bit & y_bit);
                    wl_v_next    = s2_ino_reg;
                    wl_addr_next = s2_o_reg;
                    wl_data_next = ~(x_bit & y_bit);
                end
                if (drained)
                begin
                    done_next = 1'b1;
                end
            end

            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    // Registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_reg        <= '0;
            wires_used_reg <= '0;
            gates_used_reg <= '0;
            g_reg          <= '0;
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            wl_v_reg       <= 1'b0;
            done_reg       <= 1'b0;
            read_bit_reg   <= 1'b0;
            new_id_reg     <= '0;
            status_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            wires_used_reg <= wires_used_next;
            gates_used_reg <= gates_used_next;
            g_reg          <= g_next;
            v1_reg         <= v1_next;
            v2_reg         <= v2_next;
            wl_v_reg       <= wl_v_next;
            done_reg       <= done_next;
            read_bit_reg   <= read_bit_next;
            new_id_reg     <= new_id_next;
            status_reg     <= status_next;
        end
    end

    // Pipeline payload, no reset
    always_ff @(posedge clk)
    begin
        s2_a_reg    <= s2_a_next;
        s2_b_reg    <= s2_b_next;
        s2_o_reg    <= s2_o_next;
        s2_ina_reg  <= s2_ina_next;
        s2_inb_reg  <= s2_inb_next;
        s2_ino_reg  <= s2_ino_next;
        wl_addr_reg <= wl_addr_next;
        wl_data_reg <= wl_data_next;
    end

    assign busy     = (state_reg != ST_IDLE);
    assign done     = done_reg;
    assign read_bit = read_bit_reg;
    assign new_id   = new_id_reg;
    assign status   = status_reg;

`ifndef SYNTH
    // A result always lands with the controller back at idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // Evaluate stage only follows a gate fetch
    a_pipe_order: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg |-> $past(v1_reg))
        else $error("evaluate stage without fetch");

    // A full-table error carries no id
    a_err_no_id: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status) |-> (new_id == '0 && !read_bit))
        else $error("error result carries data");

    // Gate count never passes the table depth
    a_gate_count: assert property (@(posedge clk) disable iff (!rst_n)
        gates_used_reg <= GCNT_W'(GATE_DEPTH))
        else $error("gate count overflow");
`endif

endmodule
